### hdl/kvsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvsv_pkg
// Shared types, keyword table and widths of the key/value string validator.
// ----------------------------------------------------------------------------
package kvsv_pkg;

  // widths of the string length handling
  localparam int LENGTH_BITS = 16;
  localparam int MAX_LEN_BITS = 16;
  localparam int CMP_BITS = ((LENGTH_BITS > MAX_LEN_BITS) ? LENGTH_BITS : MAX_LEN_BITS) + 1;
  localparam logic [MAX_LEN_BITS-1:0] MAX_LENGTH_RESET = 16'd4096;

  // keyword table
  localparam int KW_COUNT = 17;
  localparam int KW_SLOTS = 25;
  localparam int FIELD_COUNT = 16;
  localparam int POS_BITS = 5;
  localparam logic [POS_BITS-1:0] POS_TOP = '1;

  // each entry sits right-justified, first character in the highest used byte
  localparam logic [8*KW_SLOTS-1:0] KW_TEXT [KW_COUNT] = '{
    "host", "port", "user", "password", "dbname", "service", "servicefile",
    "sslmode", "sslrootcert", "sslcert", "sslkey", "sslcrl",
    {"channel", "_binding"}, {"target", "_session_attrs"}, {"connect", "_timeout"},
    {"application", "_name"}, {"fallback_", "application", "_name"}
  };
  localparam logic [POS_BITS-1:0] KW_LEN [KW_COUNT] = '{
    5'd4, 5'd4, 5'd4, 5'd8, 5'd6, 5'd7, 5'd11, 5'd7, 5'd11, 5'd7, 5'd6, 5'd6,
    5'd15, 5'd20, 5'd15, 5'd16, 5'd25
  };
  localparam logic [3:0] KW_BIT [KW_COUNT] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
    4'd12, 4'd13, 4'd14, 4'd15, 4'd15
  };

  // character codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

  // item types
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                   accepted;
    logic [FIELD_COUNT-1:0] field_mask;
  } out_item_t;

  // character of keyword k at position pos, zero past its end
  function automatic logic [7:0] kw_char(input int k, input logic [POS_BITS-1:0] pos);
    int sh;
    sh = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
    if (pos >= KW_LEN[k]) begin
      return 8'h00;
    end
    return KW_TEXT[k][sh +: 8];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == CH_UNDERSCORE);
  endfunction

endpackage
`default_nettype wire

### hdl/keyword_value_string_validator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_value_string_validator_unit
// Byte-serial validator of a keyword=value connection string.
// ----------------------------------------------------------------------------
// Takes one byte of the string per item and gives one result item on the byte
// marked last: the verdict and the mask of keyword fields named. The scan
// state, the 17 parallel keyword compares and the length check sit between the
// state registers, so a new item is taken every cycle. The input stalls only
// while a finished result waits on a stalled output. max_length is written
// through the cfg channel, which is always ready; write it only while no string
// is in progress.
module keyword_value_string_validator_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire kvsv_pkg::in_item_t    in_item,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      kvsv_pkg::out_item_t   out_item,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [kvsv_pkg::MAX_LEN_BITS-1:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_BETWEEN,
    PH_NAME,
    PH_VALUE_START,
    PH_UNQUOTED,
    PH_UNQUOTED_ESC,
    PH_QUOTED,
    PH_QUOTED_ESC,
    PH_AFTER_QUOTE
  } phase_t;

  localparam logic [kvsv_pkg::KW_COUNT-1:0] CAND_ALL = '1;
  localparam logic [kvsv_pkg::LENGTH_BITS-1:0] COUNT_TOP = '1;

  phase_t                                 phase, phase_next;
  logic [kvsv_pkg::KW_COUNT-1:0]          cand, cand_next, cand_base, cand_step;
  logic [kvsv_pkg::POS_BITS-1:0]          pos, pos_next, pos_base, pos_step;
  logic [kvsv_pkg::FIELD_COUNT-1:0]       seen, seen_next, hit_bits;
  logic                                   hit_any;
  logic [kvsv_pkg::LENGTH_BITS-1:0]       count, count_next;
  logic                                   reject, reject_next, reject_final;
  logic [kvsv_pkg::MAX_LEN_BITS-1:0]      max_length;
  logic [kvsv_pkg::CMP_BITS-1:0]          count_plus, max_ext;
  logic [7:0]                             c;
  logic                                   in_accept;

  assign c = in_item.text_byte;
  assign in_stall = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // name step: narrow the candidate keywords by the byte at this position
  always_comb begin
    cand_base = (phase == PH_BETWEEN) ? CAND_ALL : cand;
    pos_base = (phase == PH_BETWEEN) ? '0 : pos;
    for (int k = 0; k < kvsv_pkg::KW_COUNT; k++) begin
      cand_step[k] = cand_base[k] && (pos_base < kvsv_pkg::KW_LEN[k]) &&
                     (kvsv_pkg::kw_char(k, pos_base) == c);
    end
    pos_step = (pos_base == kvsv_pkg::POS_TOP) ? pos_base : pos_base + 1'b1;
  end

  // name end: field bit of the keyword matched in full
  always_comb begin
    hit_bits = '0;
    hit_any = 1'b0;
    for (int k = 0; k < kvsv_pkg::KW_COUNT; k++) begin
      if (cand[k] && (kvsv_pkg::KW_LEN[k] == pos)) begin
        hit_bits[kvsv_pkg::KW_BIT[k]] = 1'b1;
        hit_any = 1'b1;
      end
    end
  end

  // length check
  assign count_plus = kvsv_pkg::CMP_BITS'(count) + 1'b1;
  assign max_ext = kvsv_pkg::CMP_BITS'(max_length);

  // scan step for one byte
  always_comb begin
    phase_next = phase;
    cand_next = cand;
    pos_next = pos;
    seen_next = seen;
    reject_next = reject;
    count_next = (count == COUNT_TOP) ? count : count + 1'b1;
    if (count_plus > max_ext) begin
      reject_next = 1'b1;
    end
    if (c == kvsv_pkg::CH_NUL) begin
      reject_next = 1'b1;
    end
    if (!reject_next) begin
      case (phase)
        PH_BETWEEN: begin
          if (kvsv_pkg::is_name_char(c)) begin
            phase_next = PH_NAME;
            cand_next = cand_step;
            pos_next = pos_step;
          end else if (!kvsv_pkg::is_space(c)) begin
            reject_next = 1'b1;
          end
        end
        PH_NAME: begin
          if (kvsv_pkg::is_name_char(c)) begin
            cand_next = cand_step;
            pos_next = pos_step;
          end else if (c == kvsv_pkg::CH_EQUAL) begin
            if (!hit_any || ((seen & hit_bits) != '0)) begin
              reject_next = 1'b1;
            end else begin
              seen_next = seen | hit_bits;
              phase_next = PH_VALUE_START;
            end
          end else begin
            reject_next = 1'b1;
          end
        end
        PH_VALUE_START: begin
          if (c == kvsv_pkg::CH_QUOTE) begin
            phase_next = PH_QUOTED;
          end else if (c == kvsv_pkg::CH_BSLASH) begin
            phase_next = PH_UNQUOTED_ESC;
          end else if (kvsv_pkg::is_space(c)) begin
            phase_next = PH_BETWEEN;
          end else begin
            phase_next = PH_UNQUOTED;
          end
        end
        PH_UNQUOTED: begin
          if (c == kvsv_pkg::CH_BSLASH) begin
            phase_next = PH_UNQUOTED_ESC;
          end else if (kvsv_pkg::is_space(c)) begin
            phase_next = PH_BETWEEN;
          end
        end
        PH_UNQUOTED_ESC: begin
          phase_next = PH_UNQUOTED;
        end
        PH_QUOTED: begin
          if (c == kvsv_pkg::CH_BSLASH) begin
            phase_next = PH_QUOTED_ESC;
          end else if (c == kvsv_pkg::CH_QUOTE) begin
            phase_next = PH_AFTER_QUOTE;
          end
        end
        PH_QUOTED_ESC: begin
          phase_next = PH_QUOTED;
        end
        PH_AFTER_QUOTE: begin
          if (kvsv_pkg::is_space(c)) begin
            phase_next = PH_BETWEEN;
          end else begin
            reject_next = 1'b1;
          end
        end
        default: begin
          reject_next = 1'b1;
        end
      endcase
    end
    // verdict at end of string
    reject_final = reject_next || (seen_next == '0) || (phase_next == PH_NAME) ||
                   (phase_next == PH_QUOTED) || (phase_next == PH_QUOTED_ESC) ||
                   (phase_next == PH_UNQUOTED_ESC);
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BETWEEN;
      cand <= CAND_ALL;
      pos <= '0;
      seen <= '0;
      count <= '0;
      reject <= 1'b0;
      max_length <= kvsv_pkg::MAX_LENGTH_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_length <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        if (in_item.last_byte) begin
          phase <= PH_BETWEEN;
          cand <= CAND_ALL;
          pos <= '0;
          seen <= '0;
          count <= '0;
          reject <= 1'b0;
          out_valid <= 1'b1;
          out_item.accepted <= !reject_final;
          out_item.field_mask <= reject_final ? '0 : seen_next;
        end else begin
          phase <= phase_next;
          cand <= cand_next;
          pos <= pos_next;
          seen <= seen_next;
          count <= count_next;
          reject <= reject_next;
        end
      end
    end
  end

endmodule
`default_nettype wire
